FILE: sv/drhd_pkg.sv
// ----------------------------------------------------------------------------
// drhd_pkg: shared types and constants of the history decimator
// Sample and row types, channel codes, and the structs passed between the top
// level and the averaging unit.
// ----------------------------------------------------------------------------
package drhd_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned NUM_CH   = 5;
  localparam int unsigned CH_W     = 3;
  localparam int unsigned IDX_W    = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NUM_CH-1:0]       row_t;
  typedef logic [CH_W-1:0]            chan_t;

  // channel slots within one history row
  localparam chan_t CH_INSIDE   = 3'd0;
  localparam chan_t CH_OUTSIDE  = 3'd1;
  localparam chan_t CH_ACTUATOR = 3'd2;
  localparam chan_t CH_SETPOINT = 3'd3;
  localparam chan_t CH_ENABLE   = 3'd4;

  localparam sample_t HEATER_POWER = 12'sd60;
  localparam sample_t COOLER_POWER = 12'sd30;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    HIST_SHORT = 1'b0,
    HIST_LONG  = 1'b1
  } hist_e;

  // accepted push toward the averaging unit
  typedef struct packed {
    logic vld;
    row_t row;
  } push_t;

  // averaging unit status and long-history write
  typedef struct packed {
    logic busy;
    logic wr;
    row_t row;
  } avg_t;

endpackage

FILE: sv/drhd_if.sv
// ----------------------------------------------------------------------------
// drhd_in_if / drhd_out_if: valid/ready channels of the history decimator
// Command channel (push or read) and read-result channel.
// ----------------------------------------------------------------------------
interface drhd_in_if import drhd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic signed [11:0]  inside_temp;
  logic signed [11:0]  outside_temp;
  logic                heater_on;
  logic                cooler_on;
  logic signed [11:0]  target_temp;
  logic                control_enabled;
  logic                history_select;
  logic [CH_W-1:0]     read_channel;
  logic [IDX_W-1:0]    read_index;

  modport source (
    output valid, op, inside_temp, outside_temp, heater_on, cooler_on,
           target_temp, control_enabled, history_select, read_channel, read_index,
    input  ready
  );
  modport sink (
    input  valid, op, inside_temp, outside_temp, heater_on, cooler_on,
           target_temp, control_enabled, history_select, read_channel, read_index,
    output ready
  );
endinterface

interface drhd_out_if import drhd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [11:0] read_value;

  modport source (
    output valid, read_value,
    input  ready
  );
  modport sink (
    input  valid, read_value,
    output ready
  );
endinterface

FILE: sv/drhd_avg.sv
// ----------------------------------------------------------------------------
// drhd_avg: window sums and boxcar averaging
// Keeps per-channel running sums; every DECIMATION pushes it divides the five
// window sums through one shared reciprocal multiplier and emits a long row.
// ----------------------------------------------------------------------------
module drhd_avg import drhd_pkg::*; #(
  parameter int unsigned DECIMATION = 36
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output avg_t  avg_o
);

  localparam int unsigned LOG_D  = $clog2(DECIMATION);
  localparam int unsigned SUM_W  = SAMPLE_W + LOG_D;
  localparam int unsigned PH_W   = (LOG_D > 0) ? LOG_D : 1;
  localparam int unsigned K      = SUM_W + LOG_D;
  localparam int unsigned PROD_W = SUM_W + K + 1;
  // ceil(2^K / D): exact floor division for magnitudes below 2^SUM_W
  localparam logic [K:0]            RECIP   = (K+1)'((2**K + DECIMATION - 1) / DECIMATION);
  localparam logic [PH_W-1:0]       LAST_PH = PH_W'(DECIMATION - 1);
  localparam logic signed [SUM_W:0] HALF    = (SUM_W+1)'(DECIMATION / 2);
  localparam chan_t                 LAST_CH = chan_t'(NUM_CH - 1);

  logic signed [SUM_W-1:0] sum_q  [NUM_CH];
  logic signed [SUM_W-1:0] sum_d  [NUM_CH];
  logic signed [SUM_W-1:0] win    [NUM_CH];
  logic signed [SUM_W-1:0] bank_q [NUM_CH];
  logic [PH_W-1:0]         phase_q, phase_d;
  logic                    fire;

  logic                    run_q, run_d;
  chan_t                   iss_q, iss_d;
  logic                    a_vld_q, b_vld_q, done_q;
  logic                    a_neg_q, b_neg_q;
  chan_t                   a_ch_q, b_ch_q;
  logic [SUM_W-1:0]        a_mag_q;
  logic [PROD_W-1:0]       b_prod_q;
  row_t                    row_q;

  logic signed [SUM_W:0]   num;
  logic [SUM_W:0]          num_abs;
  sample_t                 quot;

  assign fire = push_i.vld && (phase_q == LAST_PH);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      win[c]   = sum_q[c] + SUM_W'(push_i.row[c]);
      sum_d[c] = sum_q[c];
      if (fire)            sum_d[c] = '0;
      else if (push_i.vld) sum_d[c] = win[c];
    end
    phase_d = phase_q;
    if (fire)            phase_d = '0;
    else if (push_i.vld) phase_d = phase_q + PH_W'(1);
  end

  always_comb begin
    run_d = run_q;
    iss_d = iss_q;
    if (fire) begin
      run_d = 1'b1;
      iss_d = '0;
    end else if (run_q) begin
      if (iss_q == LAST_CH) run_d = 1'b0;
      iss_d = iss_q + chan_t'(1);
    end
  end

  // issue: add half the factor, split sign and magnitude
  always_comb begin
    num     = (SUM_W+1)'(bank_q[iss_q]) + HALF;
    num_abs = num[SUM_W] ? (SUM_W+1)'(-num) : (SUM_W+1)'(num);
    quot    = sample_t'(b_prod_q[K +: SAMPLE_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) sum_q[c] <= '0;
      phase_q <= '0;
      run_q   <= 1'b0;
      iss_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      for (int c = 0; c < NUM_CH; c++) sum_q[c] <= sum_d[c];
      phase_q <= phase_d;
      run_q   <= run_d;
      iss_q   <= iss_d;
      a_vld_q <= run_q;
      b_vld_q <= a_vld_q;
      done_q  <= b_vld_q && (b_ch_q == LAST_CH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int c = 0; c < NUM_CH; c++) bank_q[c] <= win[c];
    end
    if (run_q) begin
      a_neg_q <= num[SUM_W];
      a_mag_q <= num_abs[SUM_W-1:0];
      a_ch_q  <= iss_q;
    end
    if (a_vld_q) begin
      b_prod_q <= PROD_W'(a_mag_q) * PROD_W'(RECIP);
      b_neg_q  <= a_neg_q;
      b_ch_q   <= a_ch_q;
    end
    if (b_vld_q) begin
      row_q[b_ch_q] <= b_neg_q ? -quot : quot;
    end
  end

  assign avg_o.busy = run_q | a_vld_q | b_vld_q | done_q;
  assign avg_o.wr   = done_q;
  assign avg_o.row  = row_q;

endmodule

FILE: sv/dual_rate_history_decimator.sv
// ----------------------------------------------------------------------------
// dual_rate_history_decimator: five-channel short history plus boxcar long history
// Push items store one row of five channel samples; read items return one
// entry of either history, index 0 being the oldest slot and the last index the newest entry.
// ----------------------------------------------------------------------------
// Read path: a read is registered in the synchronous memory read stage and
//   then in the output register before it is offered.
// Throughput: one item per cycle unless a read result is stalled; the
//   DECIMATION-th push of each window blocks input while the shared divide
//   multiplier walks the five channel sums (issues, 2 stages, long-memory write).
// Reset: pointers, fill counts, window sums and phase clear at once; entries
//   at or beyond a history's fill count read as zero, so no clearing pass.
module dual_rate_history_decimator import drhd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 80,
  parameter int unsigned DECIMATION    = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drhd_in_if.sink     in_i,
  drhd_out_if.source  out_o
);

  localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_AW = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
  localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);
  localparam logic [SUM_AW-1:0] DEPTH_A   = SUM_AW'(HISTORY_DEPTH);

  // --------------------------------------------------------------------------
  // Handshake. A read sits in the memory-read stage (p1) and then the output
  // register; input keeps flowing as long as p1 can drain and the averaging unit is not busy.
  // --------------------------------------------------------------------------
  push_t push_s;
  avg_t  avg_s;
  logic  in_acc, push_acc, read_acc;
  logic  p1_q, p1_d, p1_adv;
  logic  out_vld_q, out_vld_d;
  sample_t out_val_q;

  assign p1_adv     = p1_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !avg_s.busy && (!p1_q || p1_adv);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push_acc   = in_acc && (in_i.op == OP_PUSH);
  assign read_acc   = in_acc && (in_i.op == OP_READ);

  // --------------------------------------------------------------------------
  // Sample row for a push
  // --------------------------------------------------------------------------
  always_comb begin
    push_s.vld                = push_acc;
    push_s.row[CH_INSIDE]     = in_i.inside_temp;
    push_s.row[CH_OUTSIDE]    = in_i.outside_temp;
    push_s.row[CH_ACTUATOR]   = (in_i.heater_on ? HEATER_POWER : sample_t'(0))
                              - (in_i.cooler_on ? COOLER_POWER : sample_t'(0));
    push_s.row[CH_SETPOINT]   = in_i.target_temp;
    push_s.row[CH_ENABLE]     = SAMPLE_W'(in_i.control_enabled);
  end

  drhd_avg #(
    .DECIMATION (DECIMATION)
  ) u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_s),
    .avg_o  (avg_s)
  );

  // --------------------------------------------------------------------------
  // Write pointers and fill counts. While a history is filling the pointer
  // equals the count; afterwards the count sticks at full.
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] short_ptr_q, short_ptr_d, long_ptr_q, long_ptr_d;
  logic [CNT_W-1:0] short_cnt_q, short_cnt_d, long_cnt_q, long_cnt_d;

  always_comb begin
    short_ptr_d = short_ptr_q;
    short_cnt_d = short_cnt_q;
    long_ptr_d  = long_ptr_q;
    long_cnt_d  = long_cnt_q;
    if (push_acc) begin
      short_ptr_d = (short_ptr_q == LAST_SLOT) ? '0 : short_ptr_q + PTR_W'(1);
      if (short_cnt_q != FULL_CNT) short_cnt_d = short_cnt_q + CNT_W'(1);
    end
    if (avg_s.wr) begin
      long_ptr_d = (long_ptr_q == LAST_SLOT) ? '0 : long_ptr_q + PTR_W'(1);
      if (long_cnt_q != FULL_CNT) long_cnt_d = long_cnt_q + CNT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Read address: oldest slot plus index, one wrap subtract. An entry is
  // valid only if its slot lies below the fill count.
  // --------------------------------------------------------------------------
  logic              hist_long;
  logic [PTR_W-1:0]  base_ptr, rd_slot;
  logic [CNT_W-1:0]  base_cnt;
  logic [SUM_AW-1:0] slot_raw, slot_wrap;
  logic              ent_ok;

  always_comb begin
    hist_long = (in_i.history_select == HIST_LONG);
    base_ptr  = hist_long ? long_ptr_q : short_ptr_q;
    base_cnt  = hist_long ? long_cnt_q : short_cnt_q;
    slot_raw  = SUM_AW'(base_ptr) + SUM_AW'(in_i.read_index);
    slot_wrap = (slot_raw >= DEPTH_A) ? slot_raw - DEPTH_A : slot_raw;
    rd_slot   = slot_wrap[PTR_W-1:0];
    ent_ok    = (SUM_AW'(in_i.read_index) < DEPTH_A)
             && (in_i.read_channel < chan_t'(NUM_CH))
             && (CNT_W'(rd_slot) < base_cnt);
  end

  // --------------------------------------------------------------------------
  // History memories: one row of five channels per entry, one write and one
  // registered read port each
  // --------------------------------------------------------------------------
  row_t short_mem [HISTORY_DEPTH];
  row_t long_mem  [HISTORY_DEPTH];
  row_t short_rd_q, long_rd_q;

  always_ff @(posedge clk_i) begin
    if (push_acc) short_mem[short_ptr_q] <= push_s.row;
    if (read_acc) short_rd_q <= short_mem[rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (avg_s.wr) long_mem[long_ptr_q] <= avg_s.row;
    if (read_acc) long_rd_q <= long_mem[rd_slot];
  end

  // --------------------------------------------------------------------------
  // Read result: pick the history and channel, zero for invalid entries
  // --------------------------------------------------------------------------
  logic    p1_long_q, p1_ok_q;
  chan_t   p1_ch_q;
  row_t    p1_row;
  sample_t p1_val;

  always_comb begin
    p1_row = p1_long_q ? long_rd_q : short_rd_q;
    p1_val = p1_ok_q ? p1_row[p1_ch_q] : sample_t'(0);
  end

  always_comb begin
    p1_d = p1_q;
    if (read_acc)    p1_d = 1'b1;
    else if (p1_adv) p1_d = 1'b0;
    out_vld_d = out_vld_q;
    if (p1_adv)           out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ptr_q <= '0;
      short_cnt_q <= '0;
      long_ptr_q  <= '0;
      long_cnt_q  <= '0;
      p1_q        <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      short_ptr_q <= short_ptr_d;
      short_cnt_q <= short_cnt_d;
      long_ptr_q  <= long_ptr_d;
      long_cnt_q  <= long_cnt_d;
      p1_q        <= p1_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_acc) begin
      p1_long_q <= hist_long;
      p1_ch_q   <= in_i.read_channel;
      p1_ok_q   <= ent_ok;
    end
    if (p1_adv) out_val_q <= p1_val;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.read_value = out_val_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (short_cnt_q <= FULL_CNT) && (long_cnt_q <= FULL_CNT))
    else $error("fill count above history depth");

  a_short_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (short_cnt_q != FULL_CNT) |-> (CNT_W'(short_ptr_q) == short_cnt_q))
    else $error("short pointer left fill count before full");

  a_long_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (long_cnt_q != FULL_CNT) |-> (CNT_W'(long_ptr_q) == long_cnt_q))
    else $error("long pointer left fill count before full");

  a_no_push_on_long_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_s.wr |-> !push_acc)
    else $error("push accepted during long history write");

  a_p1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_q && !p1_adv) |=> (p1_q && $stable(p1_ch_q) && $stable(p1_long_q)))
    else $error("stalled read result lost");

endmodule

FILE: tb/sv/tb_dual_rate_history_decimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_rate_history_decimator: self-checking bench for the history decimator
// Walks a short directed table (reset contents, field extremes, out-of-range
// reads), then a long random mix of pushes and reads. Pushes wrap the short
// history many times and fill part of the long history. Each read result is
// checked against a local model of both histories. Random idle bursts are
// inserted on the command and result channels.
// ----------------------------------------------------------------------------
module tb_dual_rate_history_decimator;
  import drhd_pkg::*;

  localparam int HIST_DEPTH   = 80;
  localparam int DECIM        = 36;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 12;    // margin for the read path and the decimation hold
  localparam int N_RANDOM     = 1000;
  localparam int CALM_ITEMS   = N_RANDOM - 200;

  typedef struct {
    op_e                op;
    sample_t            inside_t;
    sample_t            outside_t;
    sample_t            target_t;
    logic               heat;
    logic               cool;
    logic               en;
    hist_e              sel;
    chan_t              ch;
    logic [IDX_W-1:0]   idx;
    logic               known;      // expected value typed in the table
    sample_t            known_val;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  drhd_in_if  in_if ();
  drhd_out_if out_if ();

  dual_rate_history_decimator #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .DECIMATION    (DECIM)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // History model: circular stores with the write pointer marking the oldest
  // slot, window sums per channel, pushes counted since the last average.
  // --------------------------------------------------------------------------
  sample_t short_mem [NUM_CH][HIST_DEPTH];
  sample_t long_mem  [NUM_CH][HIST_DEPTH];
  int      short_wp;
  int      long_wp;
  int      window_sum [NUM_CH];
  int      window_cnt;

  sample_t pending_values [$];   // read values still owed by the block
  int      mismatches;
  int      idle_cycles;
  int      ready_hold;
  bit      calm;                 // no idling on either side

  function automatic void hist_clear();
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        short_mem[c][i] = '0;
        long_mem[c][i]  = '0;
      end
      window_sum[c] = 0;
    end
    short_wp   = 0;
    long_wp    = 0;
    window_cnt = 0;
  endfunction

  function automatic void hist_push(item_t it);
    sample_t row [NUM_CH];
    int      avg;
    row[CH_INSIDE]   = it.inside_t;
    row[CH_OUTSIDE]  = it.outside_t;
    // actuator power: heater adds 60, cooler takes 30
    row[CH_ACTUATOR] = (it.heat ? HEATER_POWER : sample_t'(0)) -
                       (it.cool ? COOLER_POWER : sample_t'(0));
    row[CH_SETPOINT] = it.target_t;
    row[CH_ENABLE]   = it.en ? sample_t'(1) : sample_t'(0);
    for (int c = 0; c < NUM_CH; c++) begin
      short_mem[c][short_wp] = row[c];
      window_sum[c] += int'(row[c]);
    end
    short_wp = (short_wp + 1 >= HIST_DEPTH) ? 0 : short_wp + 1;
    window_cnt++;
    if (window_cnt >= DECIM) begin
      window_cnt = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        // rounded boxcar average; int division truncates toward zero
        avg = (window_sum[c] + DECIM / 2) / DECIM;
        long_mem[c][long_wp] = sample_t'(avg);
        window_sum[c] = 0;
      end
      long_wp = (long_wp + 1 >= HIST_DEPTH) ? 0 : long_wp + 1;
    end
  endfunction

  function automatic sample_t hist_lookup(item_t it);
    int slot;
    if (int'(it.ch) >= NUM_CH || int'(it.idx) >= HIST_DEPTH) return '0;
    slot = ((it.sel == HIST_LONG) ? long_wp : short_wp) + int'(it.idx);
    if (slot >= HIST_DEPTH) slot -= HIST_DEPTH;
    return (it.sel == HIST_LONG) ? long_mem[it.ch][slot] : short_mem[it.ch][slot];
  endfunction

  // --------------------------------------------------------------------------
  // Item builders. Fields that the operation ignores get random junk.
  // --------------------------------------------------------------------------
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(-2048);
      1:       return sample_t'(2047);
      2:       return sample_t'($urandom_range(0, 7) - 4);
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic item_t rand_fill(op_e op);
    item_t it;
    it.op        = op;
    it.inside_t  = rand_sample();
    it.outside_t = rand_sample();
    it.target_t  = rand_sample();
    it.heat      = 1'($urandom_range(0, 1));
    it.cool      = 1'($urandom_range(0, 1));
    it.en        = 1'($urandom_range(0, 1));
    it.sel       = hist_e'($urandom_range(0, 1));
    it.ch        = chan_t'($urandom_range(0, 7));
    it.idx       = IDX_W'($urandom_range(0, 127));
    it.known     = 1'b0;
    it.known_val = '0;
    return it;
  endfunction

  function automatic item_t mk_push(int ins, int outs, logic heat, logic cool,
                                    int tgt, logic en);
    item_t it;
    it           = rand_fill(OP_PUSH);
    it.inside_t  = sample_t'(ins);
    it.outside_t = sample_t'(outs);
    it.heat      = heat;
    it.cool      = cool;
    it.target_t  = sample_t'(tgt);
    it.en        = en;
    return it;
  endfunction

  // known = 0: the model supplies the expected value
  function automatic item_t mk_read(hist_e sel, int ch, int idx, logic known, int val);
    item_t it;
    it           = rand_fill(OP_READ);
    it.sel       = sel;
    it.ch        = chan_t'(ch);
    it.idx       = IDX_W'(idx);
    it.known     = known;
    it.known_val = sample_t'(val);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Command driver. Called at a clock edge; returns at the edge where the
  // transaction is taken, after updating the model for it. valid stays high
  // between back-to-back items.
  // --------------------------------------------------------------------------
  task automatic drive_item(item_t it);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.op              <= it.op;
    in_if.inside_temp     <= it.inside_t;
    in_if.outside_temp    <= it.outside_t;
    in_if.heater_on       <= it.heat;
    in_if.cooler_on       <= it.cool;
    in_if.target_temp     <= it.target_t;
    in_if.control_enabled <= it.en;
    in_if.history_select  <= it.sel;
    in_if.read_channel    <= it.ch;
    in_if.read_index      <= it.idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (it.op == OP_PUSH) hist_push(it);
    else pending_values.push_back(it.known ? it.known_val : hist_lookup(it));
  endtask

  // result sink: random stall bursts, none once calm
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      if (ready_hold == 0) out_if.ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(1, 8);
      out_if.ready <= 1'b0;
    end
  end

  // result checker: oldest owed value against each result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected read result %0d, nothing owed", out_if.read_value);
      end else begin
        if (out_if.read_value !== pending_values[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: expected %0d, got %0d",
                     pending_values[0], out_if.read_value);
        end
        void'(pending_values.pop_front());
      end
    end
  end

  // watchdog: a run of cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    item_t table_rows [$];
    item_t it;
    int    n_rand;

    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.op              = OP_PUSH;
    in_if.inside_temp     = '0;
    in_if.outside_temp    = '0;
    in_if.heater_on       = 1'b0;
    in_if.cooler_on       = 1'b0;
    in_if.target_temp     = '0;
    in_if.control_enabled = 1'b0;
    in_if.history_select  = HIST_SHORT;
    in_if.read_channel    = '0;
    in_if.read_index      = '0;
    out_if.ready          = 1'b1;
    ready_hold            = 0;
    mismatches            = 0;
    idle_cycles           = 0;
    calm                  = 1'b0;
    hist_clear();

    // both histories read as zero after reset; bad channel or index reads zero
    table_rows.push_back(mk_read(HIST_SHORT, CH_INSIDE, 0, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_LONG, CH_ENABLE, HIST_DEPTH - 1, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_SHORT, 7, 0, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_LONG, 5, 3, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_INSIDE, 127, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_LONG, CH_ACTUATOR, HIST_DEPTH, 1'b1, 0));
    // extremes, heater only; the newest entry is the last index
    table_rows.push_back(mk_push(2047, -2048, 1'b1, 1'b0, 2047, 1'b1));
    table_rows.push_back(mk_read(HIST_SHORT, CH_INSIDE, HIST_DEPTH - 1, 1'b1, 2047));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ACTUATOR, HIST_DEPTH - 1, 1'b1, 60));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ENABLE, HIST_DEPTH - 1, 1'b1, 1));
    // opposite extremes, cooler only
    table_rows.push_back(mk_push(-2048, 2047, 1'b0, 1'b1, -2048, 1'b0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_OUTSIDE, HIST_DEPTH - 1, 1'b1, 2047));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ACTUATOR, HIST_DEPTH - 1, 1'b1, -30));
    table_rows.push_back(mk_read(HIST_SHORT, CH_SETPOINT, HIST_DEPTH - 1, 1'b1, -2048));
    table_rows.push_back(mk_read(HIST_SHORT, CH_INSIDE, HIST_DEPTH - 2, 1'b1, 2047));
    // both actuators, then neither
    table_rows.push_back(mk_push(-1, 1, 1'b1, 1'b1, 0, 1'b1));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ACTUATOR, HIST_DEPTH - 1, 1'b1, 30));
    table_rows.push_back(mk_push(0, -1, 1'b0, 1'b0, 1, 1'b0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ACTUATOR, HIST_DEPTH - 1, 1'b1, 0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_ENABLE, HIST_DEPTH - 2, 1'b0, 0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_SETPOINT, HIST_DEPTH - 3, 1'b0, 0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_OUTSIDE, HIST_DEPTH - 4, 1'b0, 0));
    table_rows.push_back(mk_read(HIST_SHORT, CH_INSIDE, HIST_DEPTH - 5, 1'b0, 0));
    table_rows.push_back(mk_read(HIST_LONG, CH_INSIDE, HIST_DEPTH - 1, 1'b0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) drive_item(table_rows[i]);

    // random part: mostly pushes so the short history wraps many times and
    // the long history fills in part; reads spread over both histories, with
    // some bad channels and indexes
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      if ($urandom_range(0, 99) < 85) begin
        it = rand_fill(OP_PUSH);
      end else begin
        it = rand_fill(OP_READ);
        it.ch  = ($urandom_range(0, 9) == 0) ? chan_t'($urandom_range(5, 7))
                                             : chan_t'($urandom_range(0, 4));
        it.idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(HIST_DEPTH, 127))
                                             : IDX_W'($urandom_range(0, HIST_DEPTH - 1));
      end
      if (n_rand >= CALM_ITEMS) calm = 1'b1;
      drive_item(it);
      n_rand++;
    end
    in_if.valid <= 1'b0;

    // drain: every owed result, then let the pipeline settle
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
